// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the transliteration unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed in transliteration unit");

// Checked at every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed in transliteration unit");

`endif

// ===== rtl/dwx_pkg.sv =====
// Package with types, constants and the letter table of the transliteration unit.
`default_nettype none

package dwx_pkg;

    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned JOB_CNT_W   = 3;
    localparam int unsigned APB_ADDR_W  = 3;
    localparam int unsigned APB_DATA_W  = 32;

    localparam logic [APB_ADDR_W-1:0] REG_FINAL_SCHWA_ADDR = 3'd0;
    localparam logic                  FINAL_SCHWA_RESET    = 1'b1;

    localparam logic [7:0] LEAD_A4 = 8'hA4;
    localparam logic [7:0] LEAD_A5 = 8'hA5;
    localparam logic [7:0] CHAR_A  = 8'h61;
    localparam logic [7:0] CHAR_Z  = 8'h5A;

    localparam logic [6:0] IDX_NUKTA        = 7'd60;
    localparam logic [6:0] IDX_VIRAMA       = 7'd77;
    localparam logic [6:0] IDX_CONS_FIRST   = 7'd21;
    localparam logic [6:0] IDX_CONS_LAST    = 7'd57;
    localparam logic [6:0] IDX_SIGN_FIRST   = 7'd62;
    localparam logic [6:0] IDX_SIGN_LAST    = 7'd76;
    localparam logic [6:0] IDX_DROP_FIRST   = 7'd78;
    localparam logic [6:0] IDX_DROP_LAST    = 7'd95;
    localparam logic [6:0] IDX_TABLE_END    = 7'd112;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [JOB_CNT_W-1:0]         count;
        logic [MAX_RESULTS-1:0][7:0]  chars;
    } t_job;

    typedef enum logic [2:0] {
        SEQ_IDLE   = 3'b001,
        SEQ_SECOND = 3'b010,
        SEQ_THIRD  = 3'b100
    } t_seq_state;

    function automatic logic [7:0] wx_char(input logic [6:0] idx);
        logic [7:0] c;
        case (idx)
            7'd1:    c = "z";
            7'd2:    c = "M";
            7'd3:    c = "H";
            7'd5:    c = "a";
            7'd6:    c = "A";
            7'd7:    c = "i";
            7'd8:    c = "I";
            7'd9:    c = "u";
            7'd10:   c = "U";
            7'd11:   c = "q";
            7'd12:   c = "L";
            7'd15:   c = "e";
            7'd16:   c = "E";
            7'd19:   c = "o";
            7'd20:   c = "O";
            7'd21:   c = "k";
            7'd22:   c = "K";
            7'd23:   c = "g";
            7'd24:   c = "G";
            7'd25:   c = "f";
            7'd26:   c = "c";
            7'd27:   c = "C";
            7'd28:   c = "j";
            7'd29:   c = "J";
            7'd30:   c = "F";
            7'd31:   c = "t";
            7'd32:   c = "T";
            7'd33:   c = "d";
            7'd34:   c = "D";
            7'd35:   c = "N";
            7'd36:   c = "w";
            7'd37:   c = "W";
            7'd38:   c = "x";
            7'd39:   c = "X";
            7'd40:   c = "n";
            7'd41:   c = "n";
            7'd42:   c = "p";
            7'd43:   c = "P";
            7'd44:   c = "b";
            7'd45:   c = "B";
            7'd46:   c = "m";
            7'd47:   c = "y";
            7'd48:   c = "r";
            7'd49:   c = "r";
            7'd50:   c = "l";
            7'd53:   c = "v";
            7'd54:   c = "S";
            7'd55:   c = "R";
            7'd56:   c = "s";
            7'd57:   c = "h";
            7'd60:   c = "Z";
            7'd62:   c = "A";
            7'd63:   c = "i";
            7'd64:   c = "I";
            7'd65:   c = "u";
            7'd66:   c = "U";
            7'd67:   c = "q";
            7'd68:   c = "Q";
            7'd71:   c = "e";
            7'd72:   c = "E";
            7'd75:   c = "o";
            7'd76:   c = "O";
            7'd96:   c = "Q";
            7'd100:  c = ".";
            7'd101:  c = ".";
            7'd102:  c = "0";
            7'd103:  c = "1";
            7'd104:  c = "2";
            7'd105:  c = "3";
            7'd106:  c = "4";
            7'd107:  c = "5";
            7'd108:  c = "6";
            7'd109:  c = "7";
            7'd110:  c = "8";
            7'd111:  c = "9";
            default: c = " ";
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dwx_front.sv =====
// Front end: accepts input bytes, tracks UTF-8 groups and the inherent vowel, builds output jobs.
`default_nettype none
`include "assert_macros.svh"

module dwx_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire dwx_pkg::t_in_item i_item,
    input  wire logic            i_full,
    input  wire logic            i_final_schwa_en,
    output logic                 o_stall,
    output logic                 o_push_valid,
    output dwx_pkg::t_job        o_push_job
);

    dwx_pkg::t_seq_state r_seq, n_seq;
    logic [7:0]          r_held0, n_held0;
    logic [7:0]          r_held1, n_held1;
    logic                r_pend, n_pend;

    logic                               accept;
    logic                               is_letter;
    logic [6:0]                         idx;
    logic [7:0]                         table_char;
    logic [dwx_pkg::MAX_RESULTS-1:0][7:0] job_chars;
    logic [dwx_pkg::JOB_CNT_W-1:0]      job_cnt;

    assign o_stall    = i_full;
    assign accept     = i_valid && !i_full;
    assign is_letter  = ((r_held1 == dwx_pkg::LEAD_A4) || (r_held1 == dwx_pkg::LEAD_A5))
                        && (i_item.in_byte[7:6] == 2'b10);
    assign idx        = {r_held1 == dwx_pkg::LEAD_A5, i_item.in_byte[5:0]};
    assign table_char = dwx_pkg::wx_char(idx);

    always_comb begin
        job_chars = '0;
        job_cnt   = '0;
        n_seq     = r_seq;
        n_held0   = r_held0;
        n_held1   = r_held1;
        n_pend    = r_pend;
        if (accept) begin
            case (r_seq)
                dwx_pkg::SEQ_IDLE: begin
                    if (!i_item.in_byte[7]) begin
                        if (n_pend) begin
                            job_chars[job_cnt[1:0]] = dwx_pkg::CHAR_A;
                            job_cnt = job_cnt + 3'd1;
                            n_pend = 1'b0;
                        end
                        job_chars[job_cnt[1:0]] = i_item.in_byte;
                        job_cnt = job_cnt + 3'd1;
                    end else begin
                        n_held0 = i_item.in_byte;
                        n_seq   = dwx_pkg::SEQ_SECOND;
                    end
                end
                dwx_pkg::SEQ_SECOND: begin
                    n_held1 = i_item.in_byte;
                    n_seq   = dwx_pkg::SEQ_THIRD;
                end
                dwx_pkg::SEQ_THIRD: begin
                    n_seq = dwx_pkg::SEQ_IDLE;
                    if (!is_letter) begin
                        if (n_pend) begin
                            job_chars[job_cnt[1:0]] = dwx_pkg::CHAR_A;
                            job_cnt = job_cnt + 3'd1;
                            n_pend = 1'b0;
                        end
                        job_chars[job_cnt[1:0]] = r_held0;
                        job_cnt = job_cnt + 3'd1;
                        job_chars[job_cnt[1:0]] = r_held1;
                        job_cnt = job_cnt + 3'd1;
                        job_chars[job_cnt[1:0]] = i_item.in_byte;
                        job_cnt = job_cnt + 3'd1;
                    end else if (idx == dwx_pkg::IDX_NUKTA) begin
                        job_chars[job_cnt[1:0]] = dwx_pkg::CHAR_Z;
                        job_cnt = job_cnt + 3'd1;
                    end else if (idx inside {[dwx_pkg::IDX_SIGN_FIRST:dwx_pkg::IDX_SIGN_LAST]})
                    begin
                        n_pend = 1'b0;
                        job_chars[job_cnt[1:0]] = table_char;
                        job_cnt = job_cnt + 3'd1;
                    end else if (idx == dwx_pkg::IDX_VIRAMA) begin
                        n_pend = 1'b0;
                    end else begin
                        if (n_pend) begin
                            job_chars[job_cnt[1:0]] = dwx_pkg::CHAR_A;
                            job_cnt = job_cnt + 3'd1;
                            n_pend = 1'b0;
                        end
                        if (!(idx inside {[dwx_pkg::IDX_DROP_FIRST:dwx_pkg::IDX_DROP_LAST]})
                            && (idx < dwx_pkg::IDX_TABLE_END)) begin
                            job_chars[job_cnt[1:0]] = table_char;
                            job_cnt = job_cnt + 3'd1;
                            if (idx inside {[dwx_pkg::IDX_CONS_FIRST:dwx_pkg::IDX_CONS_LAST]})
                            begin
                                n_pend = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    n_seq = dwx_pkg::SEQ_IDLE;
                end
            endcase
            if (i_item.end_of_text) begin
                n_seq = dwx_pkg::SEQ_IDLE;
                if (n_pend) begin
                    if (i_final_schwa_en) begin
                        job_chars[job_cnt[1:0]] = dwx_pkg::CHAR_A;
                        job_cnt = job_cnt + 3'd1;
                    end
                    n_pend = 1'b0;
                end
            end
        end
    end

    assign o_push_valid     = accept && (job_cnt != '0);
    assign o_push_job.count = job_cnt;
    assign o_push_job.chars = job_chars;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= dwx_pkg::SEQ_IDLE;
            r_pend <= 1'b0;
        end else begin
            r_seq  <= n_seq;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

    `ASSERT_CLK(a_second_follows_first, i_clk, i_rst_n,
        (accept && (r_seq == dwx_pkg::SEQ_SECOND) && !i_item.end_of_text)
        |=> (r_seq == dwx_pkg::SEQ_THIRD))

endmodule

`default_nettype wire

// ===== rtl/dwx_fifo.sv =====
// Short job queue between the front end and the output sequencer.
`default_nettype none
`include "assert_macros.svh"

module dwx_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire dwx_pkg::t_job i_job,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_valid,
    output dwx_pkg::t_job   o_job
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    dwx_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `ASSERT_CLK(a_count_bounded, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `ASSERT_CLK(a_stored_job_nonempty, i_clk, i_rst_n,
        (do_push |-> (i_job.count != '0)))

endmodule

`default_nettype wire

// ===== rtl/dwx_back.sv =====
// Output sequencer: takes queued jobs and sends their characters one per transaction.
`default_nettype none
`include "assert_macros.svh"

module dwx_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_valid,
    input  wire dwx_pkg::t_job i_job,
    input  wire logic          i_stall,
    output logic               o_pop,
    output logic               o_valid,
    output dwx_pkg::t_out_item o_item
);

    dwx_pkg::t_job r_job;
    logic          r_busy;
    logic [1:0]    r_pos;
    logic          last;
    logic          load;

    assign last    = ({1'b0, r_pos} + 3'd1) == r_job.count;
    assign load    = !r_busy || (!i_stall && last);
    assign o_pop   = load && i_job_valid;
    assign o_valid = r_busy;

    assign o_item.out_char = r_job.chars[r_pos];
    assign o_item.run_last = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (load) begin
            r_busy <= i_job_valid;
            r_pos  <= '0;
        end else if (!i_stall) begin
            r_pos  <= r_pos + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_job;
        end
    end

    `ASSERT_CLK(a_pos_within_job, i_clk, i_rst_n,
        r_busy |-> (({1'b0, r_pos} < r_job.count) && (r_job.count != '0)))

endmodule

`default_nettype wire

// ===== rtl/devanagari_utf8_to_wx_unit.sv =====
// An accepted byte's characters pass through the job queue and then the output job register
// before the first of them is offered.
// Throughput: one byte per cycle, as long as the job queue has room.
// Each result is one output transaction, so a byte giving k characters holds the output for all k.
// Reset clears the group state, the pending vowel, the queue and the output stage.
// Reset sets final_schwa_enable to 1; there is no clearing pass.
`default_nettype none

module devanagari_utf8_to_wx_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire dwx_pkg::t_in_item                 i_in_item,
    output logic                                   o_stall,
    output logic                                   o_valid,
    output dwx_pkg::t_out_item                     o_out_item,
    input  wire logic                              i_stall,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dwx_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dwx_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dwx_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    logic          r_final_schwa_en;
    logic          reg_sel;
    logic          full;
    logic          push_valid;
    dwx_pkg::t_job push_job;
    logic          q_valid;
    dwx_pkg::t_job q_job;
    logic          pop;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[dwx_pkg::APB_ADDR_W-1:2]
                      == dwx_pkg::REG_FINAL_SCHWA_ADDR[dwx_pkg::APB_ADDR_W-1:2]);
    assign prdata  = reg_sel ? {{(dwx_pkg::APB_DATA_W-1){1'b0}}, r_final_schwa_en} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_schwa_en <= dwx_pkg::FINAL_SCHWA_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_final_schwa_en <= pwdata[0];
        end
    end

    dwx_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_item           (i_in_item),
        .i_full           (full),
        .i_final_schwa_en (r_final_schwa_en),
        .o_stall          (o_stall),
        .o_push_valid     (push_valid),
        .o_push_job       (push_job)
    );

    dwx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    dwx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .i_stall     (i_stall),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire
